>>> rtl/core/tick_driven_uart_8n1_defines.svh
// assertion macros for the tick driven uart block
// needs clk and rst_n in scope at the point of use
`ifndef TICK_DRIVEN_UART_8N1_DEFINES_SVH
`define TICK_DRIVEN_UART_8N1_DEFINES_SVH

`ifndef SYNTHESIS
`define TDU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tdu assertion failed");
`define TDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdu assertion failed");
`else
`define TDU_ASSERT(lbl, prop)
`define TDU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/tdu_pkg.sv
// shared types and constants for the tick driven uart block
// no dependencies
package tdu_pkg;

    localparam int DataWidth = 8;
    localparam int CountWidth = 4;
    localparam int AddrWidth = 4;
    localparam int ApbDataWidth = 32;

    localparam logic [CountWidth-1:0] LenMin = CountWidth'(2);
    localparam logic [CountWidth-1:0] LenMax = CountWidth'(DataWidth + 1);
    localparam logic [CountWidth-1:0] LenReset = CountWidth'(9);

    typedef enum logic [1:0] {
        REG_WORD_LENGTH = 2'd0,
        REG_TX_INVERT   = 2'd1,
        REG_RX_ENABLE   = 2'd2
    } reg_index_t;

    // input word, last field in the lowest bit
    typedef struct packed {
        logic [3:0] pad;
        logic       rx_level;
        logic       rx_tick;
        logic       tx_tick;
        logic [7:0] load_byte;
        logic       load_valid;
    } in_word_t;

    // result word, last field in the lowest bit
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic       rx_active;
        logic       load_rejected;
        logic       tx_active;
        logic       tx_line;
    } out_word_t;

endpackage

>>> rtl/core/tick_driven_uart_8n1.sv
// tick driven uart framer and deframer, 8n1, with apb configuration
// depends on tdu_pkg and tick_driven_uart_8n1_defines.svh
//
// channel   dir  width  contents
// s_axis    in   16     load_valid, load_byte, tx_tick, rx_tick, rx_level
// m_axis    out  16     tx_line, tx_active, load_rejected, rx_active, rx_done, rx_byte
// apb       in   32     word_length @0x0, tx_invert @0x4, rx_enable @0x8
//
// one word per cycle while s_tready is high; results are registered in the head or skid entry
// the uart state updates in the same edge that accepts the word
// a two-entry result buffer keeps s_tready high while only the head entry is held
// s_tready drops only while both result entries are full
// reset is asynchronous and needs no clearing pass
`include "tick_driven_uart_8n1_defines.svh"

module tick_driven_uart_8n1
    import tdu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata, // load_valid, load_byte, tx_tick, rx_tick, rx_level
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata, // tx_line, tx_active, load_rejected,
                                             // rx_active, rx_done, rx_byte
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrWidth-1:0]    paddr,
    input  logic [ApbDataWidth-1:0] pwdata,
    output logic [ApbDataWidth-1:0] prdata,
    output logic                    pready
);

    logic [CountWidth-1:0] word_length_reg;
    logic                  tx_invert_reg;
    logic                  rx_enable_reg;

    logic [DataWidth-1:0]  tx_hold_reg, tx_hold_next;
    logic [DataWidth-1:0]  tx_shifter_reg, tx_shifter_next;
    logic [CountWidth-1:0] tx_bits_reg, tx_bits_next;
    logic                  tx_busy_reg, tx_busy_next;
    logic                  tx_level_reg, tx_level_next;
    logic [DataWidth-1:0]  rx_shifter_reg, rx_shifter_next;
    logic [CountWidth-1:0] rx_bits_reg, rx_bits_next;
    logic                  rx_busy_reg, rx_busy_next;
    logic                  rx_last_reg, rx_last_next;
    logic [DataWidth-1:0]  rx_result_reg, rx_result_next;

    out_word_t head_reg, skid_reg;
    logic      head_valid_reg, skid_valid_reg;

    in_word_t              in_word;
    out_word_t             res_word;
    logic                  push, pop, cfg_write;
    logic                  rejected, done;
    logic [CountWidth-1:0] eff_len, tx_dec, rx_dec;
    reg_index_t            cfg_index;

    assign in_word   = in_word_t'(s_tdata);
    assign push      = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = head_valid_reg;
    assign m_tdata   = 16'(head_reg);
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= LenReset;
            tx_invert_reg   <= 1'b0;
            rx_enable_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WORD_LENGTH: word_length_reg <= pwdata[CountWidth-1:0];
                REG_TX_INVERT:   tx_invert_reg   <= pwdata[0];
                REG_RX_ENABLE:   rx_enable_reg   <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_WORD_LENGTH: prdata = ApbDataWidth'(word_length_reg);
            REG_TX_INVERT:   prdata = ApbDataWidth'(tx_invert_reg);
            REG_RX_ENABLE:   prdata = ApbDataWidth'(rx_enable_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (word_length_reg < LenMin)
            eff_len = LenMin;
        else if (word_length_reg > LenMax)
            eff_len = LenMax;
        else
            eff_len = word_length_reg;
    end

    assign tx_dec = tx_bits_reg - CountWidth'(1);
    assign rx_dec = rx_bits_reg - CountWidth'(1);

    // per-word state update
    always_comb
    begin
        tx_hold_next    = tx_hold_reg;
        tx_shifter_next = tx_shifter_reg;
        tx_bits_next    = tx_bits_reg;
        tx_busy_next    = tx_busy_reg;
        tx_level_next   = tx_level_reg;
        rx_shifter_next = rx_shifter_reg;
        rx_bits_next    = rx_bits_reg;
        rx_busy_next    = rx_busy_reg;
        rx_result_next  = rx_result_reg;
        rx_last_next    = in_word.rx_level;
        rejected        = 1'b0;
        done            = 1'b0;

        if (tx_busy_reg && in_word.tx_tick)
        begin
            if (tx_bits_reg == '0)
            begin
                // start bit, byte moves into the shifter
                tx_level_next   = tx_invert_reg;
                tx_shifter_next = tx_invert_reg ? ~tx_hold_reg : tx_hold_reg;
                tx_bits_next    = eff_len;
            end
            else
            begin
                tx_bits_next = tx_dec;
                if (tx_dec == '0)
                begin
                    tx_level_next = !tx_invert_reg;
                    tx_busy_next  = 1'b0;
                end
                else
                begin
                    tx_level_next   = tx_shifter_reg[0];
                    tx_shifter_next = tx_shifter_reg >> 1;
                end
            end
        end
        if (in_word.load_valid)
        begin
            if (tx_busy_reg)
                rejected = 1'b1;
            else
            begin
                tx_hold_next = in_word.load_byte[DataWidth-1:0];
                tx_bits_next = '0;
                tx_busy_next = 1'b1;
            end
        end

        if (rx_busy_reg && in_word.rx_tick)
        begin
            rx_bits_next = rx_dec;
            if (rx_dec == '0)
            begin
                rx_busy_next   = 1'b0;
                rx_result_next = rx_shifter_reg;
                done           = 1'b1;
            end
            else
                rx_shifter_next = {in_word.rx_level, rx_shifter_reg[DataWidth-1:1]};
        end
        // falling edge arms the receiver
        if (!rx_busy_reg && rx_enable_reg && rx_last_reg && !in_word.rx_level)
        begin
            rx_busy_next = 1'b1;
            rx_bits_next = LenMax;
        end
    end

    always_comb
    begin
        res_word               = '0;
        res_word.tx_line       = tx_level_next;
        res_word.tx_active     = tx_busy_next;
        res_word.load_rejected = rejected;
        res_word.rx_active     = rx_busy_next;
        res_word.rx_done       = done;
        res_word.rx_byte       = 8'(rx_result_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_hold_reg    <= '0;
            tx_shifter_reg <= '0;
            tx_bits_reg    <= '0;
            tx_busy_reg    <= 1'b0;
            tx_level_reg   <= 1'b1;
            rx_shifter_reg <= '0;
            rx_bits_reg    <= '0;
            rx_busy_reg    <= 1'b0;
            rx_last_reg    <= 1'b1;
            rx_result_reg  <= '0;
        end
        else if (push)
        begin
            tx_hold_reg    <= tx_hold_next;
            tx_shifter_reg <= tx_shifter_next;
            tx_bits_reg    <= tx_bits_next;
            tx_busy_reg    <= tx_busy_next;
            tx_level_reg   <= tx_level_next;
            rx_shifter_reg <= rx_shifter_next;
            rx_bits_reg    <= rx_bits_next;
            rx_busy_reg    <= rx_busy_next;
            rx_last_reg    <= rx_last_next;
            rx_result_reg  <= rx_result_next;
        end
    end

    // result buffer, head plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
                head_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            head_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
                head_reg <= res_word;
            else
                skid_reg <= res_word;
        end
    end

    `TDU_ASSERT(a_skid_needs_head, !skid_valid_reg || head_valid_reg)
    `TDU_ASSERT(a_stall_only_when_full, s_tready || m_tvalid)
    `TDU_ASSERT(a_tx_count_range, tx_bits_reg <= LenMax)
    `TDU_ASSERT(a_rx_count_range, rx_bits_reg <= LenMax)
    `TDU_ASSERT_NEXT(a_tx_ends_on_tick, push && !in_word.tx_tick, !$fell(tx_busy_reg))
    `TDU_ASSERT_NEXT(a_done_frees_rx, push && done, !rx_busy_reg)

endmodule
